// ===== src/stq_pkg.sv =====
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types and constants of the sorted timer queue: command and status
// codes, field widths and the controller state type.
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam int MAX_TIMERS_DEF = 64;
    localparam int TIME_W         = 48;
    localparam int TAG_W          = 32;
    localparam int DELAY_W        = 32;
    localparam int CMD_W          = 2;
    localparam int STATUS_W       = 3;

    localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SCHEDULE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CANCEL   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_SCHEDULED  = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL       = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_CANCELLED  = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_EXPIRED    = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_NONE_EXPIRED = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCHED_WALK,
        ST_SCHED_INSERT,
        ST_SCHED_LINK,
        ST_CANCEL_WALK,
        ST_TICK_WALK,
        ST_EMIT
    } stq_state_t;

endpackage

// ===== src/sorted_timer_queue_unit.sv =====
// Schedule: the identifier search and the list walk, then the insert and, with a predecessor, the link.
// Cancel: a walk to the predecessor entry, then the entry is unlinked.
// Tick: when empty, straight to the result; else one result per expired timer, or one if none expire.
// One transaction is in progress at a time; the result register frees the input side.
// Reset empties the queue, clears time and the identifier counter; no clearing pass.
// ----------------------------------------------------------------------------
// sorted_timer_queue_unit
// Timer queue kept as a singly linked list sorted by expiry, stored in an
// entry memory indexed by identifier slot, with a tick, schedule and cancel
// sequencer and an output register.
// ----------------------------------------------------------------------------
module sorted_timer_queue_unit
    import stq_pkg::*;
#(
    parameter int MAX_TIMERS = MAX_TIMERS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    output logic                            cmd_ready,
    input  logic [CMD_W-1:0]                command,
    input  logic [DELAY_W-1:0]              delay_ms,
    input  logic [TAG_W-1:0]                user_tag,
    input  logic [$clog2(MAX_TIMERS+1)-1:0] cancel_id,
    output logic                            res_valid,
    input  logic                            res_ready,
    output logic [STATUS_W-1:0]             status,
    output logic [$clog2(MAX_TIMERS+1)-1:0] timer_id,
    output logic [TAG_W-1:0]                expired_tag,
    output logic [$clog2(MAX_TIMERS+1)-1:0] pending_count,
    output logic                            last
);

    localparam int SLOT_W = $clog2(MAX_TIMERS);
    localparam int ID_W   = $clog2(MAX_TIMERS + 1);

    stq_state_t state_reg, state_next;

    logic [TIME_W-1:0]     now_reg, now_next;
    logic [ID_W-1:0]       count_reg, count_next;
    logic [SLOT_W-1:0]     head_reg, head_next;
    logic [SLOT_W-1:0]     next_slot_reg, next_slot_next;
    logic [MAX_TIMERS-1:0] in_use_reg, in_use_next;
    logic                  res_valid_reg, res_valid_next;
    logic                  held_reg, held_next;
    logic                  walk_done_reg, walk_done_next;
    logic                  id_found_reg, id_found_next;
    logic                  prev_valid_reg, prev_valid_next;

    logic [TIME_W-1:0]   exp_reg, exp_next;
    logic [TAG_W-1:0]    tag_reg, tag_next;
    logic [SLOT_W-1:0]   cur_reg, cur_next;
    logic [SLOT_W-1:0]   prev_reg, prev_next;
    logic [TIME_W-1:0]   prev_exp_reg, prev_exp_next;
    logic [TAG_W-1:0]    prev_tag_reg, prev_tag_next;
    logic [SLOT_W-1:0]   succ_reg, succ_next;
    logic [ID_W-1:0]     remain_reg, remain_next;
    logic [SLOT_W-1:0]   cand_reg, cand_next;
    logic [SLOT_W-1:0]   cslot_reg, cslot_next;

    logic [STATUS_W-1:0] hold_status_reg, hold_status_next;
    logic [ID_W-1:0]     hold_id_reg, hold_id_next;
    logic [TAG_W-1:0]    hold_tag_reg, hold_tag_next;
    logic [ID_W-1:0]     hold_pend_reg, hold_pend_next;

    logic [STATUS_W-1:0] status_reg, status_next;
    logic [ID_W-1:0]     timer_id_reg, timer_id_next;
    logic [TAG_W-1:0]    expired_tag_reg, expired_tag_next;
    logic [ID_W-1:0]     pending_count_reg, pending_count_next;
    logic                last_reg, last_next;

    logic                mem_we;
    logic [SLOT_W-1:0]   mem_waddr;
    logic [TIME_W-1:0]   mem_wexpiry;
    logic [TAG_W-1:0]    mem_wtag;
    logic [SLOT_W-1:0]   mem_wnext;
    logic                mem_re;
    logic [SLOT_W-1:0]   mem_raddr;
    logic [TIME_W-1:0]   rd_expiry;
    logic [TAG_W-1:0]    rd_tag;
    logic [SLOT_W-1:0]   rd_next;

    logic                cmd_fire;
    logic                out_free;
    logic                out_load;
    logic                load_last;
    logic                expired;
    logic                is_full;
    logic [ID_W-1:0]     cid_m1;
    logic [SLOT_W-1:0]   cid_slot;
    logic                cid_ok;

    stq_entry_ram #(
        .MAX_TIMERS(MAX_TIMERS)
    ) u_entry_ram (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wexpiry (mem_wexpiry),
        .wtag    (mem_wtag),
        .wnext   (mem_wnext),
        .re      (mem_re),
        .raddr   (mem_raddr),
        .rexpiry (rd_expiry),
        .rtag    (rd_tag),
        .rnext   (rd_next)
    );

    assign cmd_ready = (state_reg == ST_IDLE);
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign out_free  = !res_valid_reg || res_ready;
    assign expired   = (rd_expiry <= now_reg);
    assign is_full   = (count_reg == ID_W'(MAX_TIMERS));
    assign cid_m1    = cancel_id - ID_W'(1);
    assign cid_slot  = cid_m1[SLOT_W-1:0];
    assign cid_ok    = (cancel_id != '0) && (cancel_id <= ID_W'(MAX_TIMERS))
                       && in_use_reg[cid_slot];

    assign res_valid     = res_valid_reg;
    assign status        = status_reg;
    assign timer_id      = timer_id_reg;
    assign expired_tag   = expired_tag_reg;
    assign pending_count = pending_count_reg;
    assign last          = last_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    unique case (command)
                        CMD_TICK:
                        begin
                            state_next = (count_reg == '0) ? ST_EMIT : ST_TICK_WALK;
                        end
                        CMD_SCHEDULE:
                        begin
                            state_next = is_full ? ST_EMIT : ST_SCHED_WALK;
                        end
                        CMD_CANCEL:
                        begin
                            state_next = cid_ok ? ST_CANCEL_WALK : ST_EMIT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCHED_WALK:
            begin
                if (walk_done_reg && id_found_reg)
                begin
                    state_next = ST_SCHED_INSERT;
                end
            end
            ST_SCHED_INSERT:
            begin
                state_next = prev_valid_reg ? ST_SCHED_LINK : ST_EMIT;
            end
            ST_SCHED_LINK:
            begin
                state_next = ST_EMIT;
            end
            ST_CANCEL_WALK:
            begin
                if (cur_reg == cslot_reg)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_TICK_WALK:
            begin
                if (held_reg)
                begin
                    if (out_free)
                    begin
                        if (!expired)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (count_reg == ID_W'(1))
                        begin
                            state_next = ST_EMIT;
                        end
                    end
                end
                else if (!expired || count_reg == ID_W'(1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        now_next         = now_reg;
        count_next       = count_reg;
        head_next        = head_reg;
        next_slot_next   = next_slot_reg;
        in_use_next      = in_use_reg;
        held_next        = held_reg;
        walk_done_next   = walk_done_reg;
        id_found_next    = id_found_reg;
        prev_valid_next  = prev_valid_reg;
        exp_next         = exp_reg;
        tag_next         = tag_reg;
        cur_next         = cur_reg;
        prev_next        = prev_reg;
        prev_exp_next    = prev_exp_reg;
        prev_tag_next    = prev_tag_reg;
        succ_next        = succ_reg;
        remain_next      = remain_reg;
        cand_next        = cand_reg;
        cslot_next       = cslot_reg;
        hold_status_next = hold_status_reg;
        hold_id_next     = hold_id_reg;
        hold_tag_next    = hold_tag_reg;
        hold_pend_next   = hold_pend_reg;
        mem_we           = 1'b0;
        mem_waddr        = cand_reg;
        mem_wexpiry      = exp_reg;
        mem_wtag         = tag_reg;
        mem_wnext        = succ_reg;
        mem_re           = 1'b0;
        mem_raddr        = head_reg;
        out_load         = 1'b0;
        load_last        = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    unique case (command)
                        CMD_TICK:
                        begin
                            now_next         = now_reg + TIME_W'(1);
                            held_next        = 1'b0;
                            hold_status_next = STATUS_NONE_EXPIRED;
                            hold_id_next     = '0;
                            hold_tag_next    = '0;
                            hold_pend_next   = count_reg;
                            if (count_reg != '0)
                            begin
                                mem_re    = 1'b1;
                                mem_raddr = head_reg;
                            end
                        end
                        CMD_SCHEDULE:
                        begin
                            exp_next         = now_reg + TIME_W'(delay_ms);
                            tag_next         = user_tag;
                            cur_next         = head_reg;
                            prev_valid_next  = 1'b0;
                            remain_next      = count_reg;
                            walk_done_next   = (count_reg == '0);
                            id_found_next    = 1'b0;
                            cand_next        = next_slot_reg;
                            hold_status_next = STATUS_FULL;
                            hold_id_next     = '0;
                            hold_tag_next    = '0;
                            hold_pend_next   = count_reg;
                            if (!is_full && count_reg != '0)
                            begin
                                mem_re    = 1'b1;
                                mem_raddr = head_reg;
                            end
                        end
                        CMD_CANCEL:
                        begin
                            cur_next         = head_reg;
                            prev_valid_next  = 1'b0;
                            cslot_next       = cid_slot;
                            hold_status_next = STATUS_NOT_FOUND;
                            hold_id_next     = '0;
                            hold_tag_next    = '0;
                            hold_pend_next   = count_reg;
                            if (cid_ok)
                            begin
                                mem_re    = 1'b1;
                                mem_raddr = head_reg;
                            end
                        end
                        default:
                        begin
                            now_next = now_reg;
                        end
                    endcase
                end
            end
            ST_SCHED_WALK:
            begin
                if (!id_found_reg)
                begin
                    if (!in_use_reg[cand_reg])
                    begin
                        id_found_next = 1'b1;
                    end
                    else if (cand_reg == SLOT_W'(MAX_TIMERS - 1))
                    begin
                        cand_next = '0;
                    end
                    else
                    begin
                        cand_next = cand_reg + SLOT_W'(1);
                    end
                end
                if (!walk_done_reg)
                begin
                    if (rd_expiry <= exp_reg)
                    begin
                        prev_next       = cur_reg;
                        prev_valid_next = 1'b1;
                        prev_exp_next   = rd_expiry;
                        prev_tag_next   = rd_tag;
                        remain_next     = remain_reg - ID_W'(1);
                        if (remain_reg == ID_W'(1))
                        begin
                            walk_done_next = 1'b1;
                        end
                        else
                        begin
                            mem_re    = 1'b1;
                            mem_raddr = rd_next;
                            cur_next  = rd_next;
                        end
                    end
                    else
                    begin
                        succ_next      = cur_reg;
                        walk_done_next = 1'b1;
                    end
                end
            end
            ST_SCHED_INSERT:
            begin
                mem_we      = 1'b1;
                mem_waddr   = cand_reg;
                mem_wexpiry = exp_reg;
                mem_wtag    = tag_reg;
                mem_wnext   = succ_reg;
                if (!prev_valid_reg)
                begin
                    head_next = cand_reg;
                end
                count_next            = count_reg + ID_W'(1);
                in_use_next[cand_reg] = 1'b1;
                if (cand_reg == SLOT_W'(MAX_TIMERS - 1))
                begin
                    next_slot_next = '0;
                end
                else
                begin
                    next_slot_next = cand_reg + SLOT_W'(1);
                end
                hold_status_next = STATUS_SCHEDULED;
                hold_id_next     = ID_W'(cand_reg) + ID_W'(1);
                hold_tag_next    = '0;
                hold_pend_next   = count_reg + ID_W'(1);
            end
            ST_SCHED_LINK:
            begin
                mem_we      = 1'b1;
                mem_waddr   = prev_reg;
                mem_wexpiry = prev_exp_reg;
                mem_wtag    = prev_tag_reg;
                mem_wnext   = cand_reg;
            end
            ST_CANCEL_WALK:
            begin
                if (cur_reg == cslot_reg)
                begin
                    if (prev_valid_reg)
                    begin
                        mem_we      = 1'b1;
                        mem_waddr   = prev_reg;
                        mem_wexpiry = prev_exp_reg;
                        mem_wtag    = prev_tag_reg;
                        mem_wnext   = rd_next;
                    end
                    else
                    begin
                        head_next = rd_next;
                    end
                    count_next             = count_reg - ID_W'(1);
                    in_use_next[cslot_reg] = 1'b0;
                    hold_status_next       = STATUS_CANCELLED;
                    hold_id_next           = ID_W'(cslot_reg) + ID_W'(1);
                    hold_tag_next          = '0;
                    hold_pend_next         = count_reg - ID_W'(1);
                end
                else
                begin
                    prev_next       = cur_reg;
                    prev_valid_next = 1'b1;
                    prev_exp_next   = rd_expiry;
                    prev_tag_next   = rd_tag;
                    mem_re          = 1'b1;
                    mem_raddr       = rd_next;
                    cur_next        = rd_next;
                end
            end
            ST_TICK_WALK:
            begin
                if (!held_reg || out_free)
                begin
                    if (held_reg)
                    begin
                        out_load  = 1'b1;
                        load_last = !expired;
                    end
                    if (expired)
                    begin
                        held_next             = 1'b1;
                        hold_status_next      = STATUS_EXPIRED;
                        hold_id_next          = ID_W'(head_reg) + ID_W'(1);
                        hold_tag_next         = rd_tag;
                        hold_pend_next        = count_reg - ID_W'(1);
                        count_next            = count_reg - ID_W'(1);
                        in_use_next[head_reg] = 1'b0;
                        head_next             = rd_next;
                        if (count_reg != ID_W'(1))
                        begin
                            mem_re    = 1'b1;
                            mem_raddr = rd_next;
                        end
                    end
                    else if (!held_reg)
                    begin
                        hold_status_next = STATUS_NONE_EXPIRED;
                        hold_id_next     = '0;
                        hold_tag_next    = '0;
                        hold_pend_next   = count_reg;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    load_last = 1'b1;
                end
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next     = res_valid_reg;
        status_next        = status_reg;
        timer_id_next      = timer_id_reg;
        expired_tag_next   = expired_tag_reg;
        pending_count_next = pending_count_reg;
        last_next          = last_reg;
        if (out_load)
        begin
            res_valid_next     = 1'b1;
            status_next        = hold_status_reg;
            timer_id_next      = hold_id_reg;
            expired_tag_next   = hold_tag_reg;
            pending_count_next = hold_pend_reg;
            last_next          = load_last;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            now_reg       <= '0;
            count_reg     <= '0;
            head_reg      <= '0;
            next_slot_reg <= '0;
            in_use_reg    <= '0;
            res_valid_reg <= 1'b0;
            held_reg      <= 1'b0;
            walk_done_reg <= 1'b0;
            id_found_reg  <= 1'b0;
            prev_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            now_reg       <= now_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            next_slot_reg <= next_slot_next;
            in_use_reg    <= in_use_next;
            res_valid_reg <= res_valid_next;
            held_reg      <= held_next;
            walk_done_reg <= walk_done_next;
            id_found_reg  <= id_found_next;
            prev_valid_reg <= prev_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        exp_reg           <= exp_next;
        tag_reg           <= tag_next;
        cur_reg           <= cur_next;
        prev_reg          <= prev_next;
        prev_exp_reg      <= prev_exp_next;
        prev_tag_reg      <= prev_tag_next;
        succ_reg          <= succ_next;
        remain_reg        <= remain_next;
        cand_reg          <= cand_next;
        cslot_reg         <= cslot_next;
        hold_status_reg   <= hold_status_next;
        hold_id_reg       <= hold_id_next;
        hold_tag_reg      <= hold_tag_next;
        hold_pend_reg     <= hold_pend_next;
        status_reg        <= status_next;
        timer_id_reg      <= timer_id_next;
        expired_tag_reg   <= expired_tag_next;
        pending_count_reg <= pending_count_next;
        last_reg          <= last_next;
    end

endmodule

// ===== src/stq_entry_ram.sv =====
// ----------------------------------------------------------------------------
// stq_entry_ram
// Timer entry storage, one word per identifier slot: expiry time, user tag
// and the slot of the next timer in the sorted list. One write port and one
// read port with registered read data.
// ----------------------------------------------------------------------------
module stq_entry_ram
    import stq_pkg::*;
#(
    parameter int MAX_TIMERS = MAX_TIMERS_DEF
)
(
    input  logic                          clk,
    input  logic                          we,
    input  logic [$clog2(MAX_TIMERS)-1:0] waddr,
    input  logic [TIME_W-1:0]             wexpiry,
    input  logic [TAG_W-1:0]              wtag,
    input  logic [$clog2(MAX_TIMERS)-1:0] wnext,
    input  logic                          re,
    input  logic [$clog2(MAX_TIMERS)-1:0] raddr,
    output logic [TIME_W-1:0]             rexpiry,
    output logic [TAG_W-1:0]              rtag,
    output logic [$clog2(MAX_TIMERS)-1:0] rnext
);

    localparam int SLOT_W = $clog2(MAX_TIMERS);

    logic [TIME_W-1:0] mem_expiry [MAX_TIMERS];
    logic [TAG_W-1:0]  mem_tag    [MAX_TIMERS];
    logic [SLOT_W-1:0] mem_next   [MAX_TIMERS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_expiry[waddr] <= wexpiry;
            mem_tag[waddr]    <= wtag;
            mem_next[waddr]   <= wnext;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rexpiry <= mem_expiry[raddr];
            rtag    <= mem_tag[raddr];
            rnext   <= mem_next[raddr];
        end
    end

endmodule
